>>> rtl/tilt_complementary_filter_top_defines.svh
// ----------------------------------------------------------------------------
// tilt complementary filter assertion macros
// shared property wrappers; the including module supplies clk and arst_n
// ----------------------------------------------------------------------------
`ifndef TILT_COMPLEMENTARY_FILTER_TOP_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_TOP_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define TCF_ASSERT_HOLD(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcf: same-cycle check failed");

// condition must hold in the cycle after the trigger
`define TCF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcf: next-cycle check failed");

`endif

>>> rtl/tcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_pkg
// types, constants and elaboration-time table functions for the tilt filter
// ----------------------------------------------------------------------------
package tcf_pkg;

	// field and datapath widths
	localparam int ACCEL_W     = 16;
	localparam int STATE_W     = 24;
	localparam int TAB_W       = 17;
	localparam int MUL_A_W     = 24;
	localparam int MUL_B_W     = 16;
	localparam int MUL_P_W     = 40;
	localparam int WIDE_W      = 48;
	localparam int QUO_W       = 16;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	// register map
	localparam logic [CFG_INDEX_W-1:0] REG_GYRO_STEP = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WARMUP_MS = 8'd1;
	localparam logic [CFG_DATA_W-1:0]  GYRO_STEP_RESET = 16'd655;
	localparam logic [CFG_DATA_W-1:0]  WARMUP_MS_RESET = 16'd3000;

	// tilt arithmetic
	localparam logic [15:0]        ACCEL_LIMIT   = 16'd2526;
	localparam logic [10:0]        DIV_CONST     = 11'd987;
	localparam longint             HALF_PI_Q16   = 102944;
	localparam logic signed [19:0] PI_OFFSET_Q16 = 20'sd52;
	localparam int                 TILT_Q21_SHIFT = 5;

	// integration and blending
	localparam int                 GYRO_SHIFT  = 7;
	localparam int                 BLEND_SHIFT = 15;
	localparam int                 OUT_SHIFT   = 8;
	localparam logic [MUL_B_W-1:0] PITCH_KEEP  = 16'd26214;
	localparam logic [MUL_B_W-1:0] PITCH_MIX   = 16'd6554;
	localparam logic signed [WIDE_W-1:0] PITCH_ROUND = 48'sd16384;
	localparam logic signed [WIDE_W-1:0] ROLL_ROUND  = 48'sd1;
	localparam logic signed [STATE_W-1:0] STATE_MAX = 24'sh7FFFFF;
	localparam logic signed [STATE_W-1:0] STATE_MIN = 24'sh800000;

	// input word
	typedef struct packed {
		logic signed [ACCEL_W-1:0] accel_x;
		logic signed [ACCEL_W-1:0] accel_y;
		logic signed [ACCEL_W-1:0] accel_z;
		logic signed [ACCEL_W-1:0] gyro_x;
		logic signed [ACCEL_W-1:0] gyro_y;
		logic [31:0]               elapsed_ms;
	} in_word_t;

	// output word
	typedef struct packed {
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic               stabilizing;
		logic               pitch_tilt_valid;
		logic               roll_tilt_valid;
		logic               accel_missing;
	} out_word_t;

	// per-axis tilt result, Q3.21
	typedef struct packed {
		logic                      valid;
		logic signed [STATE_W-1:0] tilt;
	} tilt_res_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_DIV,
		L_RD0,
		L_RD1,
		L_RD2,
		L_MUL
	} lane_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_START,
		T_RUN,
		T_BLEND_GO,
		T_BLEND,
		T_WRITE
	} top_state_t;

	// saturate to the 24-bit state range
	function automatic logic signed [STATE_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
		if (v > WIDE_W'(STATE_MAX)) begin
			return STATE_MAX;
		end
		if (v < WIDE_W'(STATE_MIN)) begin
			return STATE_MIN;
		end
		return v[STATE_W-1:0];
	endfunction

	// taylor term divisor (2k)(2k+1)
	function automatic logic [63:0] series_div(input int k, input logic [63:0] v);
		unique case (k)
			1: return v / 64'd6;
			2: return v / 64'd20;
			3: return v / 64'd42;
			4: return v / 64'd72;
			5: return v / 64'd110;
			6: return v / 64'd156;
			default: return v / 64'd210;
		endcase
	endfunction

	// sine of a Q.16 angle in Q.30, truncating series steps
	function automatic longint sine_q30(input longint t16);
		logic [63:0] t;
		logic [63:0] term;
		longint      sum;
		int          k;
		t    = 64'(t16) << 14;
		term = t;
		sum  = longint'(t);
		for (k = 1; k <= 7; k++) begin
			term = (term * t) >> 30;
			term = (term * t) >> 30;
			term = series_div(k, term);
			if (k[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return sum;
	endfunction

	// arcsine entry i of a table with 2^bits steps, Q.16
	function automatic logic [TAB_W-1:0] tilt_entry(input int i, input int bits);
		longint x;
		longint lo;
		longint hi;
		longint mid;
		x  = longint'(i) <<< (30 - bits);
		lo = 0;
		hi = HALF_PI_Q16;
		if (sine_q30(hi) <= x) begin
			lo = hi;
		end else begin
			while (hi - lo > 1) begin
				mid = (lo + hi) >>> 1;
				if (sine_q30(mid) <= x) begin
					lo = mid;
				end else begin
					hi = mid;
				end
			end
		end
		return lo[TAB_W-1:0];
	endfunction

endpackage

>>> rtl/tilt_complementary_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_complementary_filter_top
// Pitch/roll complementary filter. Each input word (accel Q8.8, gyro Q4.12,
// elapsed ms) gives one output word with the updated angles in Q3.13. A word
// takes longer when pitch blending runs after warm-up, and less time when
// both accel axes are out of range. The next word is taken the cycle after
// the result is written to the output register, and no new word is taken
// while one is in flight; a result still held in the output register stalls
// the write. The time per word is set by the per-axis lanes (16-step
// divider, table reads of an entry and the next one, 16-step interpolation
// multiply) and by the 16-step blend multiply. Config writes are accepted at
// any time but must be issued only while no word is in flight.
// ----------------------------------------------------------------------------
`include "tilt_complementary_filter_top_defines.svh"

module tilt_complementary_filter_top #(
	parameter int TILT_TABLE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  tcf_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tcf_pkg::out_word_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tcf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tcf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int SW = tcf_pkg::STATE_W;
	localparam int AW = tcf_pkg::MUL_A_W;
	localparam int WW = tcf_pkg::WIDE_W;

	tcf_pkg::top_state_t st_q, st_d;

	// configuration and filter state
	logic [tcf_pkg::CFG_DATA_W-1:0] gyro_step_q;
	logic [tcf_pkg::CFG_DATA_W-1:0] warmup_q;
	logic signed [SW-1:0]           pitch_q;
	logic signed [SW-1:0]           roll_q;
	logic                           out_valid_q;

	// per-word registers
	tcf_pkg::in_word_t              in_q;
	tcf_pkg::out_word_t             out_q;
	logic signed [SW-1:0]           nxt_p_q;
	logic signed [SW-1:0]           nxt_r_q;
	logic signed [SW-1:0]           pt_q;
	logic                           stab_q;
	logic                           pv_q;
	logic                           rv_q;
	logic                           miss_q;

	// unit handshakes
	logic                           lane_start;
	logic                           lane_p_busy;
	logic                           lane_r_busy;
	tcf_pkg::tilt_res_t             lane_p_res;
	tcf_pkg::tilt_res_t             lane_r_res;
	logic                           mul_start;
	logic                           blend_go;
	logic signed [AW-1:0]           mul_p_a;
	logic signed [AW-1:0]           mul_r_a;
	logic [tcf_pkg::MUL_B_W-1:0]    mul_p_b;
	logic [tcf_pkg::MUL_B_W-1:0]    mul_r_b;
	logic                           mul_p_busy;
	logic                           mul_r_busy;
	logic signed [tcf_pkg::MUL_P_W-1:0] mul_p_prod;
	logic signed [tcf_pkg::MUL_P_W-1:0] mul_r_prod;

	// update arithmetic
	logic                           units_idle;
	logic                           missing;
	logic                           stab;
	logic                           pv;
	logic                           rv;
	logic signed [SW-1:0]           pt;
	logic signed [SW-1:0]           rt;
	logic signed [SW-1:0]           pg;
	logic signed [SW-1:0]           rg;
	logic signed [SW-1:0]           rblend;
	logic signed [SW-1:0]           pblend;
	logic                           out_free;
	logic                           wr_en;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == tcf_pkg::T_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign wr_en     = (st_q == tcf_pkg::T_WRITE) && out_free;

	// status of the current word
	assign units_idle = !(lane_p_busy || lane_r_busy || mul_p_busy || mul_r_busy);
	assign missing    = (in_q.accel_x == '0) && (in_q.accel_y == '0) && (in_q.accel_z == '0);
	assign stab       = (in_q.elapsed_ms > {16'd0, warmup_q});
	assign pv         = missing || lane_p_res.valid;
	assign rv         = missing || lane_r_res.valid;
	assign pt         = missing ? '0 : lane_p_res.tilt;
	assign rt         = missing ? '0 : -lane_r_res.tilt;

	// gyro integration and blends
	assign pg     = tcf_pkg::sat24(WW'(pitch_q) + WW'(mul_p_prod >>> tcf_pkg::GYRO_SHIFT));
	assign rg     = tcf_pkg::sat24(WW'(roll_q) + WW'(mul_r_prod >>> tcf_pkg::GYRO_SHIFT));
	assign rblend = tcf_pkg::sat24((WW'(rg) + WW'(rt) + tcf_pkg::ROLL_ROUND) >>> 1);
	assign pblend = tcf_pkg::sat24((WW'(mul_p_prod) + WW'(mul_r_prod) + tcf_pkg::PITCH_ROUND)
		>>> tcf_pkg::BLEND_SHIFT);

	// multiplier operands: gyro terms first, pitch blend terms second
	assign blend_go = (st_q == tcf_pkg::T_BLEND_GO);
	assign mul_p_a  = blend_go ? nxt_p_q : AW'(in_q.gyro_y);
	assign mul_p_b  = blend_go ? tcf_pkg::PITCH_KEEP : gyro_step_q;
	assign mul_r_a  = blend_go ? pt_q : AW'(in_q.gyro_x);
	assign mul_r_b  = blend_go ? tcf_pkg::PITCH_MIX : gyro_step_q;

	tcf_tilt_lane #(
		.TILT_TABLE_BITS(TILT_TABLE_BITS)
	) u_lane_p (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.accel  (in_q.accel_x),
		.busy   (lane_p_busy),
		.result (lane_p_res)
	);

	tcf_tilt_lane #(
		.TILT_TABLE_BITS(TILT_TABLE_BITS)
	) u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.accel  (in_q.accel_y),
		.busy   (lane_r_busy),
		.result (lane_r_res)
	);

	tcf_ser_mul u_mul_p (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_p_a),
		.b       (mul_p_b),
		.busy    (mul_p_busy),
		.product (mul_p_prod)
	);

	tcf_ser_mul u_mul_r (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_r_a),
		.b       (mul_r_b),
		.busy    (mul_r_busy),
		.product (mul_r_prod)
	);

	// sequencer next state and unit starts
	always_comb begin
		st_d       = st_q;
		lane_start = 1'b0;
		mul_start  = 1'b0;
		unique case (st_q)
			tcf_pkg::T_IDLE: begin
				if (in_valid) begin
					st_d = tcf_pkg::T_START;
				end
			end
			tcf_pkg::T_START: begin
				lane_start = 1'b1;
				mul_start  = 1'b1;
				st_d       = tcf_pkg::T_RUN;
			end
			tcf_pkg::T_RUN: begin
				if (units_idle) begin
					st_d = (stab && pv) ? tcf_pkg::T_BLEND_GO : tcf_pkg::T_WRITE;
				end
			end
			tcf_pkg::T_BLEND_GO: begin
				mul_start = 1'b1;
				st_d      = tcf_pkg::T_BLEND;
			end
			tcf_pkg::T_BLEND: begin
				if (!mul_p_busy && !mul_r_busy) begin
					st_d = tcf_pkg::T_WRITE;
				end
			end
			tcf_pkg::T_WRITE: begin
				if (out_free) begin
					st_d = tcf_pkg::T_IDLE;
				end
			end
			default: st_d = tcf_pkg::T_IDLE;
		endcase
	end

	// control, configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= tcf_pkg::T_IDLE;
			gyro_step_q <= tcf_pkg::GYRO_STEP_RESET;
			warmup_q    <= tcf_pkg::WARMUP_MS_RESET;
			pitch_q     <= '0;
			roll_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					tcf_pkg::REG_GYRO_STEP: gyro_step_q <= cfg_data;
					tcf_pkg::REG_WARMUP_MS: warmup_q    <= cfg_data;
					default: ;
				endcase
			end
			if (wr_en) begin
				pitch_q     <= nxt_p_q;
				roll_q      <= nxt_r_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// word datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
		end
		if ((st_q == tcf_pkg::T_RUN) && units_idle) begin
			stab_q <= stab;
			pv_q   <= pv;
			rv_q   <= rv;
			miss_q <= missing;
			pt_q   <= pt;
			if (stab) begin
				nxt_p_q <= pg;
				nxt_r_q <= rv ? rblend : rg;
			end else begin
				nxt_p_q <= pv ? pt : pitch_q;
				nxt_r_q <= rv ? rt : roll_q;
			end
		end
		if ((st_q == tcf_pkg::T_BLEND) && !mul_p_busy && !mul_r_busy) begin
			nxt_p_q <= pblend;
		end
		if (wr_en) begin
			out_q.pitch_angle      <= nxt_p_q[SW-1:tcf_pkg::OUT_SHIFT];
			out_q.roll_angle       <= nxt_r_q[SW-1:tcf_pkg::OUT_SHIFT];
			out_q.stabilizing      <= stab_q;
			out_q.pitch_tilt_valid <= pv_q;
			out_q.roll_tilt_valid  <= rv_q;
			out_q.accel_missing    <= miss_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// lanes and multipliers rest whenever no word is in flight
	`TCF_ASSERT_HOLD(a_units_rest, st_q == tcf_pkg::T_IDLE, !(lane_p_busy || lane_r_busy || mul_p_busy || mul_r_busy))
	// a multiplier is never restarted mid-run
	`TCF_ASSERT_HOLD(a_mul_free, mul_start, !mul_p_busy && !mul_r_busy)
	// filter state only moves when a result word is written
	`TCF_ASSERT_NEXT(a_state_hold, !wr_en, $stable(pitch_q) && $stable(roll_q))

endmodule

>>> rtl/tcf_asin_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_asin_rom
// arcsine lookup, 2^bits+1 entries built at elaboration, registered read
// ----------------------------------------------------------------------------
module tcf_asin_rom #(
	parameter int TILT_TABLE_BITS = 10
) (
	input  logic                       clk,
	input  logic [TILT_TABLE_BITS:0]   addr,
	output logic [tcf_pkg::TAB_W-1:0]  data
);

	localparam int TAB_SIZE = (1 << TILT_TABLE_BITS) + 1;
	localparam int DW       = tcf_pkg::TAB_W;

	logic [DW-1:0] rom_w [TAB_SIZE];
	logic [DW-1:0] data_q;

	// constant contents
	for (genvar g = 0; g < TAB_SIZE; g++) begin : g_entry
		localparam logic [DW-1:0] ENTRY = tcf_pkg::tilt_entry(g, TILT_TABLE_BITS);
		assign rom_w[g] = ENTRY;
	end

	// registered read port
	always_ff @(posedge clk) begin
		data_q <= rom_w[addr];
	end

	assign data = data_q;

endmodule

>>> rtl/tcf_ser_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_ser_mul
// bit-serial shift-add multiplier: signed 24-bit times unsigned 16-bit,
// one multiplier bit per cycle
// ----------------------------------------------------------------------------
module tcf_ser_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [tcf_pkg::MUL_A_W-1:0]  a,
	input  logic [tcf_pkg::MUL_B_W-1:0]         b,
	output logic                                busy,
	output logic signed [tcf_pkg::MUL_P_W-1:0]  product
);

	localparam int BW    = tcf_pkg::MUL_B_W;
	localparam int PW    = tcf_pkg::MUL_P_W;
	localparam int CNT_W = $clog2(BW);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [PW-1:0] mcand_q;
	logic signed [PW-1:0] acc_q;
	logic [BW-1:0]        mplier_q;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(BW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift-add datapath, lsb of the multiplier first
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= PW'(a);
			mplier_q <= b;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign busy    = busy_q;
	assign product = acc_q;

endmodule

>>> rtl/tcf_tilt_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_tilt_lane
// one axis: |a| range check, serial divide by 987, arcsine lookup with
// serial linear interpolation, tilt in Q3.21
// ----------------------------------------------------------------------------
module tcf_tilt_lane #(
	parameter int TILT_TABLE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [tcf_pkg::ACCEL_W-1:0]  accel,
	output logic                                busy,
	output tcf_pkg::tilt_res_t                  result
);

	localparam int SH = tcf_pkg::QUO_W - TILT_TABLE_BITS;
	localparam int AW = TILT_TABLE_BITS + 1;
	localparam int AW_A = tcf_pkg::MUL_A_W;
	localparam int BW = tcf_pkg::MUL_B_W;
	localparam int SW = tcf_pkg::STATE_W;
	localparam int DW = tcf_pkg::TAB_W;

	tcf_pkg::lane_state_t state_q, state_d;

	logic [9:0]                 rem_q;
	logic [15:0]                dvd_q;
	logic [tcf_pkg::QUO_W-1:0]  quo_q;
	logic [3:0]                 cnt_q;
	logic                       pos_q;
	logic [DW-1:0]              y0_q;
	tcf_pkg::tilt_res_t         res_q;

	logic [15:0]                mag;
	logic                       in_range;
	logic [11:0]                mag12;
	logic [25:0]                scaled;
	logic [10:0]                trial;
	logic                       ge;
	logic [10:0]                trial_sub;
	logic [TILT_TABLE_BITS-1:0] idx;
	logic [AW-1:0]              rom_addr;
	logic [DW-1:0]              rom_data;
	logic signed [DW:0]         diff;
	logic                       mul_start;
	logic                       mul_busy;
	logic signed [tcf_pkg::MUL_P_W-1:0] mul_prod;
	logic signed [tcf_pkg::MUL_P_W-1:0] interp;
	logic signed [18:0]         asin_q16;
	logic signed [19:0]         tilt_q16;
	logic signed [SW-1:0]       tilt_q21;

	// magnitude, range check and scaling by 25600
	assign mag      = accel[15] ? (~accel + 16'd1) : accel;
	assign in_range = (mag <= tcf_pkg::ACCEL_LIMIT);
	assign mag12    = mag[11:0];
	assign scaled   = {mag12, 14'd0} + {1'b0, mag12, 13'd0} + {4'd0, mag12, 10'd0};

	// one restoring divide step
	assign trial     = {rem_q, dvd_q[15]};
	assign ge        = (trial >= tcf_pkg::DIV_CONST);
	assign trial_sub = trial - tcf_pkg::DIV_CONST;

	// table address: entry then the next one
	assign idx      = quo_q[tcf_pkg::QUO_W-1:SH];
	assign rom_addr = (state_q == tcf_pkg::L_RD1) ? ({1'b0, idx} + AW'(1)) : {1'b0, idx};

	// interpolation
	assign diff     = $signed({1'b0, rom_data}) - $signed({1'b0, y0_q});
	assign interp   = mul_prod >>> SH;
	assign asin_q16 = $signed({2'b00, y0_q}) + interp[18:0];
	assign tilt_q16 = (pos_q ? -20'(asin_q16) : 20'(asin_q16)) - tcf_pkg::PI_OFFSET_Q16;
	assign tilt_q21 = SW'(tilt_q16) <<< tcf_pkg::TILT_Q21_SHIFT;

	tcf_asin_rom #(
		.TILT_TABLE_BITS(TILT_TABLE_BITS)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	tcf_ser_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (AW_A'(diff)),
		.b       (BW'(quo_q[SH-1:0])),
		.busy    (mul_busy),
		.product (mul_prod)
	);

	// next state
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		unique case (state_q)
			tcf_pkg::L_IDLE: begin
				if (start && in_range) begin
					state_d = tcf_pkg::L_DIV;
				end
			end
			tcf_pkg::L_DIV: begin
				if (cnt_q == 4'd15) begin
					state_d = tcf_pkg::L_RD0;
				end
			end
			tcf_pkg::L_RD0: state_d = tcf_pkg::L_RD1;
			tcf_pkg::L_RD1: state_d = tcf_pkg::L_RD2;
			tcf_pkg::L_RD2: begin
				mul_start = 1'b1;
				state_d   = tcf_pkg::L_MUL;
			end
			tcf_pkg::L_MUL: begin
				if (!mul_busy) begin
					state_d = tcf_pkg::L_IDLE;
				end
			end
			default: state_d = tcf_pkg::L_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcf_pkg::L_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tcf_pkg::L_DIV) begin
				cnt_q <= cnt_q + 4'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			tcf_pkg::L_IDLE: begin
				if (start) begin
					rem_q <= scaled[25:16];
					dvd_q <= scaled[15:0];
					pos_q <= !accel[15] && (accel != '0);
					if (!in_range) begin
						res_q.valid <= 1'b0;
						res_q.tilt  <= '0;
					end
				end
			end
			tcf_pkg::L_DIV: begin
				rem_q <= ge ? trial_sub[9:0] : trial[9:0];
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[tcf_pkg::QUO_W-2:0], ge};
			end
			tcf_pkg::L_RD1: y0_q <= rom_data;
			tcf_pkg::L_MUL: begin
				if (!mul_busy) begin
					res_q.valid <= 1'b1;
					res_q.tilt  <= tilt_q21;
				end
			end
			default: ;
		endcase
	end

	assign busy   = (state_q != tcf_pkg::L_IDLE);
	assign result = res_q;

endmodule

>>> bench/tcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_checker
// watches the config, input and output channels of the tilt filter, keeps its
// own pitch/roll state and arcsine table, predicts each output word and
// compares it field by field against the word the block hands out
// ----------------------------------------------------------------------------
module tcf_checker #(
	parameter int TABLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  tcf_pkg::in_word_t               in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  tcf_pkg::out_word_t              out_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [tcf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tcf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              mismatch_count,
	output int                              words_pending
);
	import tcf_pkg::*;

	localparam int     LUT_ENTRIES  = (1 << TABLE_BITS) + 1;
	localparam int     FRAC_BITS    = 16 - TABLE_BITS;
	localparam longint QUARTER_TURN = 102944;	// pi/2 in Q.16
	localparam longint TILT_BIAS    = 52;	// pi/2 - 1.57 in Q.16
	localparam longint ACCEL_OK_MAX = 2526;	// 9.87 m/s^2 in Q8.8
	localparam longint ANGLE_HI     = 8388607;
	localparam longint ANGLE_LO     = -8388608;

	longint    asin_lut [LUT_ENTRIES];
	logic [15:0] step_reg;
	logic [15:0] warm_reg;
	longint    pitch_acc;
	longint    roll_acc;
	out_word_t angles_due [$];
	int        mismatch_total;

	// sine of a Q.16 angle as a truncated Taylor series, Q.30 result
	function automatic longint series_sine(input longint ang);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] divisor;
		longint      acc;
		int          k;
		x    = 64'(ang) << 14;
		term = x;
		acc  = longint'(x);
		for (k = 1; k <= 7; k++) begin
			term    = (term * x) >> 30;
			term    = (term * x) >> 30;
			divisor = 64'((2 * k) * (2 * k + 1));
			term    = term / divisor;
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		return acc;
	endfunction

	// arcsine table: largest angle whose series sine stays at or below i/2^bits
	initial begin : build_lut
		longint target;
		longint lo;
		longint hi;
		longint mid;
		int     i;
		for (i = 0; i < LUT_ENTRIES; i++) begin
			target = longint'(i) << (30 - TABLE_BITS);
			lo     = 0;
			hi     = QUARTER_TURN;
			if (series_sine(hi) <= target) begin
				lo = hi;
			end else begin
				while (hi - lo > 1) begin
					mid = (lo + hi) / 2;
					if (series_sine(mid) <= target) begin
						lo = mid;
					end else begin
						hi = mid;
					end
				end
			end
			asin_lut[i] = lo;
		end
	end

	function automatic longint clamp_state(input longint v);
		if (v > ANGLE_HI) begin
			return ANGLE_HI;
		end
		if (v < ANGLE_LO) begin
			return ANGLE_LO;
		end
		return v;
	endfunction

	// tilt angle of one axis in Q.16, returns whether the axis is usable
	function automatic logic axis_tilt(input logic signed [15:0] a, output longint tilt);
		longint mag;
		longint ratio;
		longint idx;
		longint frac;
		longint base;
		mag = (a < 0) ? -longint'(a) : longint'(a);
		if (mag > ACCEL_OK_MAX) begin
			tilt = 0;
			return 1'b0;
		end
		ratio = mag * 6553600 / 252672;
		idx   = ratio >>> FRAC_BITS;
		frac  = ratio & ((longint'(1) << FRAC_BITS) - 1);
		base  = asin_lut[idx]
			+ (((asin_lut[idx + 1] - asin_lut[idx]) * frac) >>> FRAC_BITS);
		tilt  = ((a > 0) ? -base : base) - TILT_BIAS;
		return 1'b1;
	endfunction

	// advance the filter by one sample and return the word it should produce
	function automatic out_word_t advance_filter(input in_word_t w);
		out_word_t res;
		logic      missing;
		logic      settled;
		logic      pitch_ok;
		logic      roll_ok;
		longint    pitch_tilt;
		longint    roll_tilt;
		longint    p;
		longint    r;
		missing = (w.accel_x == 0) && (w.accel_y == 0) && (w.accel_z == 0);
		settled = longint'(w.elapsed_ms) > longint'(warm_reg);
		if (missing) begin
			pitch_tilt = 0;
			roll_tilt  = 0;
			pitch_ok   = 1'b1;
			roll_ok    = 1'b1;
		end else begin
			pitch_ok  = axis_tilt(w.accel_x, pitch_tilt);
			roll_ok   = axis_tilt(w.accel_y, roll_tilt);
			roll_tilt = -roll_tilt;
		end
		pitch_tilt = pitch_tilt * 32;
		roll_tilt  = roll_tilt * 32;

		if (settled) begin
			// gyro integration, then blend toward the tilt where it is usable
			p = clamp_state(pitch_acc + ((longint'(w.gyro_y) * longint'(step_reg)) >>> 7));
			r = clamp_state(roll_acc + ((longint'(w.gyro_x) * longint'(step_reg)) >>> 7));
			if (pitch_ok) begin
				p = clamp_state((26214 * p + 6554 * pitch_tilt + 16384) >>> 15);
			end
			if (roll_ok) begin
				r = clamp_state((r + roll_tilt + 1) >>> 1);
			end
			pitch_acc = p;
			roll_acc  = r;
		end else begin
			// warm-up: snap to the tilt, hold on an unusable axis
			if (pitch_ok) begin
				pitch_acc = clamp_state(pitch_tilt);
			end
			if (roll_ok) begin
				roll_acc = clamp_state(roll_tilt);
			end
		end

		res.pitch_angle      = 16'(pitch_acc >>> 8);
		res.roll_angle       = 16'(roll_acc >>> 8);
		res.stabilizing      = settled;
		res.pitch_tilt_valid = pitch_ok;
		res.roll_tilt_valid  = roll_ok;
		res.accel_missing    = missing;
		return res;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_total++;
		$display("%0t ns  mismatch: %s", $time, what);
	endtask

	task automatic compare_field(input string field, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			flag_mismatch($sformatf("%s got %h expected %h", field, got, want));
		end
	endtask

	// channel monitor: config, output check, input prediction
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			step_reg       = GYRO_STEP_RESET;
			warm_reg       = WARMUP_MS_RESET;
			pitch_acc      = 0;
			roll_acc       = 0;
			mismatch_total = 0;
			angles_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GYRO_STEP) begin
					step_reg = cfg_data;
				end else if (cfg_index == REG_WARMUP_MS) begin
					warm_reg = cfg_data;
				end
			end
			if (out_valid && out_ready) begin
				if (angles_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected output word %h", out_data));
				end else begin
					want = angles_due.pop_front();
					compare_field("pitch_angle", out_data.pitch_angle, want.pitch_angle);
					compare_field("roll_angle", out_data.roll_angle, want.roll_angle);
					compare_field("stabilizing", out_data.stabilizing, want.stabilizing);
					compare_field("pitch_tilt_valid", out_data.pitch_tilt_valid,
						want.pitch_tilt_valid);
					compare_field("roll_tilt_valid", out_data.roll_tilt_valid,
						want.roll_tilt_valid);
					compare_field("accel_missing", out_data.accel_missing,
						want.accel_missing);
				end
			end
			if (in_valid && in_ready) begin
				angles_due.push_back(advance_filter(in_data));
			end
		end
		mismatch_count <= mismatch_total;
		words_pending  <= angles_due.size();
	end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// regression for the tilt complementary filter: directed corner samples, then
// three randomized phases with different register settings and idle patterns,
// including a long output stall that backs the block up; a checker beside the
// block predicts and compares every output word
// ----------------------------------------------------------------------------
module tb;
	import tcf_pkg::*;

	localparam int RUN_LIMIT     = 600000;
	localparam int RANDOM_WORDS  = 650;
	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 64;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TOP    = 8'hFF;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	in_word_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_word_t              out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int cycle_count    = 0;
	int warmup_now     = WARMUP_MS_RESET;
	int mismatches;
	int words_pending;

	tilt_complementary_filter_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tcf_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatches),
		.words_pending  (words_pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// output side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left   <= LONG_HOLD;
			out_ready   <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic in_word_t sample(input int ax, input int ay, input int az,
			input int gx, input int gy, input logic [31:0] ms);
		in_word_t w;
		w.accel_x    = 16'(ax);
		w.accel_y    = 16'(ay);
		w.accel_z    = 16'(az);
		w.gyro_x     = 16'(gx);
		w.gyro_y     = 16'(gy);
		w.elapsed_ms = ms;
		return w;
	endfunction

	// mostly gravity-sized readings, some at the usable limit, some anything
	function automatic logic signed [15:0] random_accel();
		int pick;
		int v;
		pick = $urandom_range(99);
		if (pick < 70) begin
			v = int'($urandom_range(5052)) - 2526;
		end else if (pick < 82) begin
			v = 2525 + int'($urandom_range(2));
			if ($urandom_range(1) == 1) begin
				v = -v;
			end
		end else if (pick < 87) begin
			v = 0;
		end else begin
			v = int'($urandom);
		end
		return 16'(v);
	endfunction

	function automatic logic signed [15:0] random_rate();
		if ($urandom_range(99) < 70) begin
			return 16'(int'($urandom_range(4000)) - 2000);
		end
		return 16'($urandom);
	endfunction

	function automatic in_word_t random_sample(input int warm);
		in_word_t w;
		int       pick;
		w.accel_x = random_accel();
		w.accel_y = random_accel();
		w.accel_z = ($urandom_range(9) == 0) ? 16'sd0 : 16'($urandom);
		if ($urandom_range(99) < 4) begin
			w.accel_x = '0;
			w.accel_y = '0;
			w.accel_z = '0;
		end
		w.gyro_x = random_rate();
		w.gyro_y = random_rate();
		// elapsed time: around the warm-up edge, inside it, after it, anywhere
		pick = $urandom_range(99);
		if (pick < 15) begin
			w.elapsed_ms = $urandom_range(warm);
		end else if (pick < 27) begin
			w.elapsed_ms = 32'(warm) + $urandom_range(2) - 32'd1;
		end else if (pick < 90) begin
			w.elapsed_ms = 32'(warm) + 32'd1 + $urandom_range(100000);
		end else begin
			w.elapsed_ms = $urandom;
		end
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	// valid is dropped only after the last write of a group
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val, input logic last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (last) begin
			cfg_valid <= 1'b0;
		end
		if (idx == REG_WARMUP_MS) begin
			warmup_now = val;
		end
	endtask

	task automatic drain();
		do @(posedge clk); while (words_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int phase;
		int i;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 6;
		recv_stall_pct <= 76;
		@(posedge clk);

		// corners with reset register values
		send_word(sample(0, 0, 0, 0, 0, 0));
		send_word(sample(2526, -2526, 100, 0, 0, 10));
		send_word(sample(2527, -2527, 100, 0, 0, 20));
		send_word(sample(32767, -32768, -32768, 32767, -32768, 30));
		send_word(sample(-32768, 32767, 32767, -32768, 32767, 40));
		send_word(sample(0, 0, 1, 0, 0, 50));
		send_word(sample(1, -1, 0, 0, 0, 60));
		send_word(sample(-1, 1, 0, 0, 0, 3000));
		send_word(sample(600, -900, 2500, 32767, -32768, 3001));
		send_word(sample(-1200, 300, 2500, -32768, 32767, 32'hFFFF_FFFF));
		send_word(sample(5000, -5000, 0, 1000, -1000, 32'hFFFF_FFFF));
		send_word(sample(0, 0, 0, 500, -500, 4000));
		in_valid <= 1'b0;
		drain();

		// largest step, no warm-up, writes to unmapped indexes
		write_reg(REG_GYRO_STEP, 16'hFFFF, 1'b0);
		write_reg(REG_WARMUP_MS, 16'h0000, 1'b0);
		write_reg(REG_UNUSED, 16'h1234, 1'b0);
		write_reg(REG_TOP, 16'hFFFF, 1'b1);
		send_word(sample(2000, -2000, 0, 0, 0, 0));
		send_word(sample(9000, 9000, 1, 32767, 32767, 1));
		send_word(sample(9000, 9000, 1, 32767, 32767, 1));
		send_word(sample(2526, 2526, 1, 32767, 32767, 2));
		send_word(sample(-9000, -9000, 1, -32768, -32768, 3));
		send_word(sample(-9000, -9000, 1, -32768, -32768, 3));
		send_word(sample(-2526, -2526, 1, -32768, -32768, 4));
		in_valid <= 1'b0;
		drain();

		// zero step disables integration, longest warm-up
		write_reg(REG_GYRO_STEP, 16'h0000, 1'b0);
		write_reg(REG_WARMUP_MS, 16'hFFFF, 1'b1);
		send_word(sample(1000, 1000, 0, 32767, 32767, 65536));
		send_word(sample(1000, 1000, 0, -32768, -32768, 65535));
		in_valid <= 1'b0;
		drain();

		// random phases, each with its own settings and idle pattern
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_GYRO_STEP, 16'($urandom_range(65535, 1)), 1'b0);
					write_reg(REG_WARMUP_MS, 16'($urandom_range(5000)), 1'b1);
				end
				1: begin
					send_idle_pct = 76;
					recv_stall_pct <= 6;
					write_reg(REG_GYRO_STEP, 16'd1, 1'b0);
					write_reg(REG_WARMUP_MS, 16'hFFFF, 1'b1);
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
					write_reg(REG_GYRO_STEP, GYRO_STEP_RESET, 1'b0);
					write_reg(REG_WARMUP_MS, WARMUP_MS_RESET, 1'b1);
				end
			endcase
			for (i = 0; i < RANDOM_WORDS / 3; i++) begin
				// long output stall while words keep coming
				if (phase == 2 && i == 60) begin
					hold_requests <= hold_requests + 1;
				end
				send_word(random_sample(warmup_now));
			end
			in_valid <= 1'b0;
			drain();
		end

		if (mismatches == 0 && words_pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

>>> tilt_complementary_filter_top.f
+incdir+rtl
rtl/tcf_pkg.sv
rtl/tcf_asin_rom.sv
rtl/tcf_ser_mul.sv
rtl/tcf_tilt_lane.sv
rtl/tilt_complementary_filter_top.sv
bench/tcf_checker.sv
bench/tb.sv
